// ----- src/lnds_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the longest non-decreasing subsequence block.
package lnds_pkg;

  localparam int unsigned LNDS_DEPTH = 4096;
  localparam int unsigned VALUE_W    = 31;
  localparam int unsigned LONGEST_W  = 13;

  // One result as handed from the controller to the output stage.
  typedef struct packed {
    logic [LONGEST_W-1:0] longest;
    logic                 overflow;
  } lnds_res_t;

endpackage

// ----- src/lnds_tails_ram.sv -----
`timescale 1ns / 1ps
// Tails memory: one write port, one read port with registered read data.
module lnds_tails_ram import lnds_pkg::*; #(
  parameter int unsigned DEPTH = LNDS_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  output logic [VALUE_W-1:0]         rd_data_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  logic [VALUE_W-1:0]         wr_data_i
);

  logic [VALUE_W-1:0] mem_q [DEPTH];
  logic [VALUE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/lnds_ctrl.sv -----
`timescale 1ns / 1ps
// Search and update sequencer: binary search over the tails memory, then at most one write.
module lnds_ctrl import lnds_pkg::*; #(
  parameter int unsigned DEPTH = LNDS_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       start_new_i,
  input  logic [VALUE_W-1:0]         value_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output lnds_res_t                  res_o,
  output logic                       rd_en_o,
  output logic [$clog2(DEPTH)-1:0]   rd_addr_o,
  input  logic [VALUE_W-1:0]         rd_data_i,
  output logic                       wr_en_o,
  output logic [$clog2(DEPTH)-1:0]   wr_addr_o,
  output logic [VALUE_W-1:0]         wr_data_o
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned LEN_W  = $clog2(DEPTH + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_e;

  state_e             state_q, state_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [LEN_W-1:0]   lo_q, lo_d;
  logic [LEN_W-1:0]   hi_q, hi_d;
  logic [LEN_W-1:0]   mid_q, mid_d;
  logic [VALUE_W-1:0] x_q, x_d;

  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W-1:0]   lo_n, hi_n;
  logic [LEN_W:0]     mid_sum;
  logic               tail_le;
  logic               ovf;
  logic [LEN_W+LONGEST_W-1:0] len_ext;

  assign len_eff = start_new_i ? '0 : len_q;
  assign tail_le = (rd_data_i <= x_q);
  assign lo_n    = tail_le ? (mid_q + LEN_W'(1)) : lo_q;
  assign hi_n    = tail_le ? hi_q : mid_q;
  assign len_ext = {{LONGEST_W{1'b0}}, len_d};

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    x_d         = x_q;
    mid_sum     = '0;
    ovf         = 1'b0;
    rd_en_o     = 1'b0;
    wr_en_o     = 1'b0;
    wr_addr_o   = lo_q[ADDR_W-1:0];
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          x_d   = value_i;
          len_d = len_eff;
          lo_d  = '0;
          hi_d  = len_eff;
          mid_d = len_eff >> 1;
          if (len_eff != '0) begin
            rd_en_o = 1'b1;
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_UPDATE;
          end
        end
      end
      ST_SEARCH: begin
        // The read issued last cycle returns now; narrow the range and
        // launch the next probe in the same cycle.
        lo_d    = lo_n;
        hi_d    = hi_n;
        mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
        mid_d   = mid_sum[LEN_W:1];
        if (lo_n < hi_n) begin
          rd_en_o = 1'b1;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
          if (lo_q < len_q) begin
            wr_en_o = 1'b1;
          end else if (len_q != LEN_MAX) begin
            wr_en_o   = 1'b1;
            wr_addr_o = len_q[ADDR_W-1:0];
            len_d     = len_q + LEN_W'(1);
          end else begin
            ovf = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_addr_o     = mid_d[ADDR_W-1:0];
  assign wr_data_o     = x_q;
  assign res_o.longest = len_ext[LONGEST_W-1:0];
  assign res_o.overflow = ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    x_q   <= x_d;
  end

`ifndef SYNTHESIS
  a_no_rd_wr_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en_o && wr_en_o))
    else $error("tails read and write issued together");

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_MAX)
    else $error("length above depth");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH && rd_en_o) |-> (mid_d < len_q))
    else $error("search probe beyond stored tails");

  a_ovf_at_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.overflow) |-> (len_q == LEN_MAX && !wr_en_o))
    else $error("overflow flagged below full length");
`endif

endmodule

// ----- src/longest_nondecreasing_subsequence_top.sv -----
`timescale 1ns / 1ps
// An accepted item runs its binary search probes over the tails memory (none when the
// length is zero), then waits in the update state for room in the output register;
// its result then enters that register and tvalid rises.
// One item at a time: the next item is accepted only after the current one's update.
// Reset: rst_ni clears the length and the control state; the tails memory is not cleared.
// Top level of the longest non-decreasing subsequence block.
//
// Each accepted item carries a value and a start flag. The controller clears the
// length on a start flag, binary-searches the tails memory for the count of
// tails not above the value, issuing one read per cycle and comparing the data
// of the previous read in the same cycle, then writes the value into the tail
// that follows and extends the length when that tail was the first unused one.
// A value that would grow a full length writes no tail and is flagged as overflow.
// The write happens in a cycle of its own before the next item can be accepted,
// so a search never reads an entry that is being written.
// A result register on the output side lets the next item be accepted and searched
// while the previous result still waits for the downstream side.
module longest_nondecreasing_subsequence_top import lnds_pkg::*; #(
  parameter int unsigned DEPTH = LNDS_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] value, [31] zero fill
  input  logic        s_axis_tuser,   // [0] start_new
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [12:0] longest, [15:13] zero fill
  output logic        m_axis_tuser    // [0] overflow
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [VALUE_W-1:0] wr_data;

  logic      res_valid;
  logic      res_ready;
  lnds_res_t res;

  // Output register state.
  logic      out_valid_q, out_valid_d;
  lnds_res_t out_res_q;

  lnds_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .start_new_i (s_axis_tuser),
    .value_i     (s_axis_tdata[VALUE_W-1:0]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  lnds_tails_ram #(
    .DEPTH (DEPTH)
  ) u_tails (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // The slot can take a new result when it is empty or being emptied now.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - LONGEST_W){1'b0}}, out_res_q.longest};
  assign m_axis_tuser  = out_res_q.overflow;

`ifndef SYNTHESIS
  a_no_result_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !res_valid)
    else $error("result loaded into a full output register");

  a_slot_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_q)
    else $error("result lost on its way to the output register");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !s_axis_tready)
    else $error("item accepted while a result is being issued");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the longest non-decreasing subsequence block.
module tb;
  import lnds_pkg::*;

  // One input item as queued for the stream driver.
  typedef struct packed {
    logic               start_new;
    logic [VALUE_W-1:0] value;
  } lnds_item_t;

  localparam int unsigned IDLE_PCT  = 37;
  localparam int unsigned HOLD_LEN  = 300;   // long receiver hold-off, in cycles
  localparam int unsigned HOLD_AT   = 500;   // results seen before the hold-off starts
  localparam int unsigned CALM_LEN  = 250;   // items accepted with no idling on either side
  localparam int unsigned RAMP_LEN  = 256;   // items in the rising ramp
  localparam int unsigned RAND_ITEMS = 770;
  localparam int unsigned SETTLE    = 24;    // cycles waited past the last result
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [30:0] value, [31] zero fill
  logic        s_axis_tuser = 1'b0; // [0] start_new
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [12:0] longest, [15:13] zero fill
  logic        m_axis_tuser;        // [0] overflow

  longest_nondecreasing_subsequence_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Items waiting to be offered, and the results the block still owes us.
  lnds_item_t pending_items[$];
  lnds_res_t  pending_longest[$];

  // Our own copy of the block's state: the tails store and the current length.
  logic [VALUE_W-1:0] tails_m [LNDS_DEPTH];
  int unsigned        seq_len = 0;

  int unsigned items_in = 0;
  int unsigned results_out = 0;
  int unsigned seq_starts = 0;
  int unsigned overflow_hits = 0;
  int unsigned deepest = 0;
  int unsigned errors = 0;
  int unsigned calm_from = 1_000_000_000;
  bit          offering = 1'b0;   // s_axis_tvalid is up and the item is not yet taken
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  logic calm;
  assign calm = (items_in >= calm_from) && (items_in < calm_from + CALM_LEN);

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Patience step: count the tails not above the value by binary search, then
  // lower the following tail, growing the length unless it is already full.
  function automatic lnds_res_t next_longest(input logic start_new,
                                             input logic [VALUE_W-1:0] v);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lnds_res_t   r;
    if (start_new) begin
      seq_len = 0;
    end
    lo = 0;
    hi = seq_len;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tails_m[mid] <= v) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    r.overflow = 1'b0;
    if (lo < seq_len) begin
      tails_m[lo] = v;
    end else if (seq_len < LNDS_DEPTH) begin
      tails_m[seq_len] = v;
      seq_len++;
    end else begin
      r.overflow = 1'b1;
    end
    r.longest = seq_len[LONGEST_W-1:0];
    return r;
  endfunction

  task automatic queue_item(input bit start_new, input logic [VALUE_W-1:0] v);
    lnds_item_t it;
    it.start_new = start_new;
    it.value     = v;
    pending_items.push_back(it);
  endtask

  // Sender pause: nothing new is offered until every owed result is back.
  task automatic wait_idle();
    while (pending_items.size() != 0 || offering || pending_longest.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Driver. Inputs move on the falling edge; once tvalid is up it stays up,
  // with the same item, until the block takes it.
  always @(negedge clk_i) begin : drive_in
    lnds_item_t nxt;
    if (rst_ni && !offering) begin
      if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = pending_items.pop_front();
        s_axis_tdata  <= {1'b0, nxt.value};
        s_axis_tuser  <= nxt.start_new;
        s_axis_tvalid <= 1'b1;
        offering = 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver. Random stalls, one long hold-off while the sender keeps
  // offering so that the block backs up and drops s_axis_tready.
  always @(negedge clk_i) begin : drive_out
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_out >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Input monitor: every accepted item is run through the predictor.
  always @(posedge clk_i) begin : watch_in
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pending_longest.push_back(next_longest(s_axis_tuser, s_axis_tdata[VALUE_W-1:0]));
      if (s_axis_tuser) begin
        seq_starts++;
      end
      items_in++;
      offering = 1'b0;
    end
  end

  // Output monitor: each result against the oldest owed one, field by field.
  always @(posedge clk_i) begin : watch_out
    lnds_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_out++;
      if (pending_longest.size() == 0) begin
        flag_mismatch($sformatf("result %0d/%0d arrived with nothing owed",
                                m_axis_tdata, m_axis_tuser));
      end else begin
        want = pending_longest.pop_front();
        if (m_axis_tdata !== {{(16 - LONGEST_W){1'b0}}, want.longest}) begin
          flag_mismatch($sformatf("result %0d: longest got 'h%0h want %0d",
                                  results_out, m_axis_tdata, want.longest));
        end
        if (m_axis_tuser !== want.overflow) begin
          flag_mismatch($sformatf("result %0d: overflow got %b want %b",
                                  results_out, m_axis_tuser, want.overflow));
        end
        if (want.overflow) begin
          overflow_hits++;
        end
        if (want.longest > deepest) begin
          deepest = want.longest;
        end
      end
    end
  end

  // Stimulus: a short directed part, a rising ramp of equal pairs and a few
  // items past its end, then random sequences of mixed shapes.
  initial begin : stimulus
    int unsigned        n;
    int unsigned        run_len;
    int unsigned        mode;
    logic [31:0]        v;
    logic [31:0]        walk;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // The first item after reset comes without a start flag; the length is zero anyway.
    queue_item(1'b0, 7);
    queue_item(1'b0, 7);             // equal value extends the length
    queue_item(1'b0, 3);
    queue_item(1'b1, VALUE_MAX);     // restart while tails are in use
    queue_item(1'b0, 0);
    queue_item(1'b0, 0);
    queue_item(1'b0, VALUE_MAX);
    queue_item(1'b0, 5);
    queue_item(1'b0, 5);
    queue_item(1'b0, 987654321);
    queue_item(1'b0, 1);
    queue_item(1'b1, 987654321);
    queue_item(1'b1, 31'h2AAA_AAAA);
    queue_item(1'b0, 31'h5555_5555);
    queue_item(1'b0, 31'h2AAA_AAAA);
    queue_item(1'b0, 31'h4000_0000);
    queue_item(1'b0, VALUE_MAX);
    queue_item(1'b0, VALUE_MAX);
    queue_item(1'b1, 0);
    queue_item(1'b0, VALUE_MAX - 31'd1);
    wait_idle();

    // A rising ramp of equal pairs grows a deep sequence; past its end large
    // values extend it and a smaller one only lowers a tail.
    for (int i = 0; i < RAMP_LEN; i++) begin
      queue_item(i == 0, VALUE_W'((i >> 1) * 1_000_000));
    end
    queue_item(1'b0, VALUE_MAX);
    queue_item(1'b0, VALUE_MAX);
    queue_item(1'b0, 1000);
    queue_item(1'b0, VALUE_MAX);
    queue_item(1'b1, 3);             // restart from a deep store
    queue_item(1'b0, 2);
    wait_idle();

    // Random part. Most runs start a fresh sequence; some carry on the old one.
    calm_from = items_in + 300;
    n = 0;
    while (n < RAND_ITEMS) begin
      run_len = ($urandom_range(9) == 0) ? $urandom_range(400, 150) : $urandom_range(40, 1);
      if (run_len > RAND_ITEMS - n) begin
        run_len = RAND_ITEMS - n;
      end
      mode    = $urandom_range(3);
      walk    = $urandom_range(32'h7000_0000);
      for (int k = 0; k < run_len; k++) begin
        case (mode)
          0: v = $urandom;
          1: v = $urandom_range(15);
          2: begin
            // Mostly rising values with occasional drops, so lengths grow deep.
            walk = walk + $urandom_range(3000);
            v = ($urandom_range(4) == 0) ? $urandom_range(walk) : walk;
          end
          default: begin
            case ($urandom_range(3))
              0: v = 0;
              1: v = 1;
              2: v = VALUE_MAX - 1;
              default: v = VALUE_MAX;
            endcase
          end
        endcase
        queue_item((k == 0) && ($urandom_range(7) != 0), v[VALUE_W-1:0]);
        n++;
      end
    end
    wait_idle();
    repeat (SETTLE) @(posedge clk_i);

    $display("Covered %0d items in %0d started sequences, %0d results checked.",
             items_in, seq_starts, results_out);
    $display("Deepest length %0d, %0d overflow results, %0d mismatches.",
             deepest, overflow_hits, errors);
    if (errors == 0 && pending_longest.size() == 0) begin
      $display("longest_nondecreasing_subsequence_top verification clean");
    end else begin
      $display("longest_nondecreasing_subsequence_top verification failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest expected run.
  initial begin : watchdog
    #8_000_000;
    $display("Timeout with %0d results still owed.", pending_longest.size());
    $display("longest_nondecreasing_subsequence_top verification failed");
    $finish;
  end

endmodule
